>>> rtl/json_token_lexer_assert.svh
// Assertion macros used by the lexer queue.
`ifndef JSON_TOKEN_LEXER_ASSERT_SVH
`define JSON_TOKEN_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define JTL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JTL_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define JTL_ASSERT(label, clk, rst_n, prop, msg)
`define JTL_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

>>> rtl/jtl_pkg.sv
package jtl_pkg;
	localparam logic [4:0] TK_COLON     = 5'd0;
	localparam logic [4:0] TK_COMMA     = 5'd1;
	localparam logic [4:0] TK_LBRACKET  = 5'd2;
	localparam logic [4:0] TK_RBRACKET  = 5'd3;
	localparam logic [4:0] TK_LBRACE    = 5'd4;
	localparam logic [4:0] TK_RBRACE    = 5'd5;
	localparam logic [4:0] TK_TRUE      = 5'd6;
	localparam logic [4:0] TK_STR_OPEN  = 5'd9;
	localparam logic [4:0] TK_STR_CHAR  = 5'd10;
	localparam logic [4:0] TK_STR_CLOSE = 5'd11;
	localparam logic [4:0] TK_NUM_CHAR  = 5'd12;
	localparam logic [4:0] TK_INT_END   = 5'd13;
	localparam logic [4:0] TK_FLOAT_END = 5'd14;
	localparam logic [4:0] TK_END       = 5'd15;
	localparam logic [4:0] TK_ERROR     = 5'd16;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_INVALID_CHAR = 3'd1;
	localparam logic [2:0] ERR_EXP_DIGIT    = 3'd2;
	localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd3;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd4;
	localparam logic [2:0] ERR_UNTERM       = 3'd5;

	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [7:0]  char_value;
		logic [2:0]  error_code;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        last_of_run;
	} out_item_t;

	// one token event
	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] ch;
		logic [2:0] err;
	} ev_t;

	// all events of one input byte
	typedef struct packed {
		ev_t         ev0;
		ev_t         ev1;
		logic        two;
		logic [15:0] line;
		logic [15:0] col;
	} rec_t;
endpackage

>>> rtl/jtl_front.sv
module jtl_front #(
	parameter int POS_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  jtl_pkg::in_item_t item,
	output logic             wr,
	output jtl_pkg::rec_t    rec
);
	import jtl_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_LIT, M_NSIGN, M_NINT, M_NDOT, M_NFRAC, M_NEXP,
		M_NEXPS, M_NEXPD, M_STR, M_ESC, M_HEX, M_ERR
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [2:0]          lit_idx_q, lit_idx_d;
	logic [1:0]          lit_which_q, lit_which_d;
	logic                is_float_q, is_float_d;
	logic [7:0]          hex_acc_q, hex_acc_d;
	logic [1:0]          hex_cnt_q, hex_cnt_d;
	logic [POS_BITS-1:0] line_q, col_q;

	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		case ({w, i})
			{2'd0, 3'd0}: c = "t";
			{2'd0, 3'd1}: c = "r";
			{2'd0, 3'd2}: c = "u";
			{2'd0, 3'd3}: c = "e";
			{2'd1, 3'd0}: c = "f";
			{2'd1, 3'd1}: c = "a";
			{2'd1, 3'd2}: c = "l";
			{2'd1, 3'd3}: c = "s";
			{2'd1, 3'd4}: c = "e";
			{2'd2, 3'd0}: c = "n";
			{2'd2, 3'd1}: c = "u";
			{2'd2, 3'd2}: c = "l";
			{2'd2, 3'd3}: c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	logic [7:0] b;
	logic       is_end;
	assign b      = item.text_byte;
	assign is_end = item.end_of_text;

	// decode a byte seen between tokens
	logic       idle_has;
	ev_t        idle_ev;
	mode_t      idle_mode;
	logic       idle_lit;
	logic [1:0] idle_which;

	always_comb begin
		idle_has   = 1'b1;
		idle_ev    = '{kind: TK_COLON, ch: 8'h00, err: ERR_NONE};
		idle_mode  = M_IDLE;
		idle_lit   = 1'b0;
		idle_which = 2'd0;
		case (b)
			" ", 8'h09, 8'h0D, CH_LF: idle_has = 1'b0;
			":": idle_ev.kind = TK_COLON;
			",": idle_ev.kind = TK_COMMA;
			"[": idle_ev.kind = TK_LBRACKET;
			"]": idle_ev.kind = TK_RBRACKET;
			"{": idle_ev.kind = TK_LBRACE;
			"}": idle_ev.kind = TK_RBRACE;
			"\"": begin
				idle_ev.kind = TK_STR_OPEN;
				idle_mode    = M_STR;
			end
			"-": begin
				idle_ev.kind = TK_NUM_CHAR;
				idle_ev.ch   = b;
				idle_mode    = M_NSIGN;
			end
			"t", "f", "n": begin
				idle_has   = 1'b0;
				idle_lit   = 1'b1;
				idle_mode  = M_LIT;
				idle_which = (b == "t") ? 2'd0 : ((b == "f") ? 2'd1 : 2'd2);
			end
			default: begin
				if (is_digit(b)) begin
					idle_ev.kind = TK_NUM_CHAR;
					idle_ev.ch   = b;
					idle_mode    = M_NINT;
				end else begin
					idle_ev.kind = TK_ERROR;
					idle_ev.err  = ERR_INVALID_CHAR;
					idle_mode    = M_ERR;
				end
			end
		endcase
	end

	// hex digit value
	logic       hex_ok;
	logic [3:0] hex_val;
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (is_digit(b)) hex_val = 4'(b - "0");
		else if (b >= "a" && b <= "f") hex_val = 4'(b - "a" + 8'd10);
		else if (b >= "A" && b <= "F") hex_val = 4'(b - "A" + 8'd10);
		else hex_ok = 1'b0;
	end

	// lex one byte
	logic       has0, has1;
	ev_t        ev0, ev1;
	logic [1:0] w;
	logic [2:0] lit_len;
	logic [7:0] hex_new;
	ev_t        close_ev;

	always_comb begin
		mode_d      = mode_q;
		lit_idx_d   = lit_idx_q;
		lit_which_d = lit_which_q;
		is_float_d  = is_float_q;
		hex_acc_d   = hex_acc_q;
		hex_cnt_d   = hex_cnt_q;
		has0        = 1'b0;
		has1        = 1'b0;
		ev0         = '{kind: TK_NUM_CHAR, ch: b, err: ERR_NONE};
		ev1         = '{kind: TK_END, ch: 8'h00, err: ERR_NONE};
		w           = (lit_which_q == 2'd3) ? 2'd0 : lit_which_q;
		lit_len     = (w == 2'd1) ? 3'd5 : 3'd4;
		hex_new     = {hex_acc_q[3:0], hex_val};
		close_ev    = '{kind: is_float_q ? TK_FLOAT_END : TK_INT_END, ch: 8'h00,
			err: ERR_NONE};
		if (is_end) begin
			case (mode_q)
				M_NINT, M_NFRAC, M_NEXP, M_NEXPD: begin
					has0 = 1'b1;
					ev0  = close_ev;
				end
				M_NSIGN, M_NDOT, M_NEXPS: begin
					has0 = 1'b1;
					ev0  = '{kind: TK_ERROR, ch: 8'h00, err: ERR_EXP_DIGIT};
				end
				M_LIT, M_STR, M_ESC, M_HEX: begin
					has0 = 1'b1;
					ev0  = '{kind: TK_ERROR, ch: 8'h00, err: ERR_UNTERM};
				end
				default: has0 = 1'b0;
			endcase
			if (has0) begin
				has1 = 1'b1;
			end else begin
				has0 = 1'b1;
				ev0  = ev1;
			end
			mode_d      = M_IDLE;
			lit_idx_d   = 3'd0;
			lit_which_d = 2'd0;
			is_float_d  = 1'b0;
			hex_acc_d   = 8'h00;
			hex_cnt_d   = 2'd0;
		end else begin
			case (mode_q)
				M_LIT: begin
					if (lit_idx_q < lit_len && b == lit_char(w, lit_idx_q)) begin
						lit_idx_d = lit_idx_q + 3'd1;
						if (lit_idx_q + 3'd1 == lit_len) begin
							has0     = 1'b1;
							ev0      = '{kind: TK_TRUE + 5'(w), ch: 8'h00, err: ERR_NONE};
							mode_d   = M_IDLE;
						end
					end else begin
						has0   = 1'b1;
						ev0    = '{kind: TK_ERROR, ch: 8'h00, err: ERR_INVALID_CHAR};
						mode_d = M_ERR;
					end
				end
				M_NSIGN, M_NDOT, M_NEXPS: begin
					has0 = 1'b1;
					if (is_digit(b)) begin
						if (mode_q == M_NDOT) begin
							is_float_d = 1'b1;
							mode_d     = M_NFRAC;
						end else if (mode_q == M_NSIGN) begin
							mode_d = M_NINT;
						end else begin
							mode_d = M_NEXPD;
						end
					end else begin
						ev0    = '{kind: TK_ERROR, ch: 8'h00, err: ERR_EXP_DIGIT};
						mode_d = M_ERR;
					end
				end
				M_NINT, M_NFRAC, M_NEXP, M_NEXPD: begin
					has0 = 1'b1;
					if (is_digit(b)) begin
						if (mode_q == M_NEXP) mode_d = M_NEXPD;
					end else if (b == "." && mode_q == M_NINT) begin
						mode_d = M_NDOT;
					end else if ((b == "e" || b == "E") &&
						(mode_q == M_NINT || mode_q == M_NFRAC)) begin
						is_float_d = 1'b1;
						mode_d     = M_NEXP;
					end else if ((b == "+" || b == "-") && mode_q == M_NEXP) begin
						mode_d = M_NEXPS;
					end else begin
						// close the number, then lex the byte afresh
						ev0        = close_ev;
						has1       = idle_has;
						ev1        = idle_ev;
						mode_d     = idle_mode;
						is_float_d = 1'b0;
						if (idle_lit) begin
							lit_which_d = idle_which;
							lit_idx_d   = 3'd1;
						end
					end
				end
				M_STR: begin
					if (b == "\"") begin
						has0     = 1'b1;
						ev0.kind = TK_STR_CLOSE;
						ev0.ch   = 8'h00;
						mode_d   = M_IDLE;
					end else if (b == "\\") begin
						mode_d = M_ESC;
					end else begin
						has0     = 1'b1;
						ev0.kind = TK_STR_CHAR;
					end
				end
				M_ESC: begin
					has0     = 1'b1;
					ev0.kind = TK_STR_CHAR;
					mode_d   = M_STR;
					case (b)
						"\"", "\\", "/": ev0.ch = b;
						"b": ev0.ch = 8'h08;
						"f": ev0.ch = 8'h0C;
						"n": ev0.ch = CH_LF;
						"r": ev0.ch = 8'h0D;
						"t": ev0.ch = 8'h09;
						"u": begin
							has0      = 1'b0;
							hex_acc_d = 8'h00;
							hex_cnt_d = 2'd0;
							mode_d    = M_HEX;
						end
						default: begin
							ev0    = '{kind: TK_ERROR, ch: 8'h00, err: ERR_BAD_ESCAPE};
							mode_d = M_ERR;
						end
					endcase
				end
				M_HEX: begin
					if (!hex_ok) begin
						has0   = 1'b1;
						ev0    = '{kind: TK_ERROR, ch: 8'h00, err: ERR_BAD_HEX};
						mode_d = M_ERR;
					end else begin
						hex_acc_d = hex_new;
						if (hex_cnt_q == 2'd3) begin
							has0      = 1'b1;
							ev0       = '{kind: TK_STR_CHAR, ch: hex_new, err: ERR_NONE};
							hex_cnt_d = 2'd0;
							mode_d    = M_STR;
						end else begin
							hex_cnt_d = hex_cnt_q + 2'd1;
						end
					end
				end
				M_ERR: has0 = 1'b0;
				default: begin
					has0       = idle_has;
					ev0        = idle_ev;
					mode_d     = idle_mode;
					is_float_d = 1'b0;
					if (idle_lit) begin
						lit_which_d = idle_which;
						lit_idx_d   = 3'd1;
					end
				end
			endcase
		end
	end

	// shift a second event into the first slot when only it fires
	assign wr       = take & (has0 | has1);
	assign rec.ev0  = has0 ? ev0 : ev1;
	assign rec.ev1  = ev1;
	assign rec.two  = has0 & has1;
	assign rec.line = 16'(line_q);
	assign rec.col  = 16'(col_q);

	// advance state and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			lit_idx_q   <= 3'd0;
			lit_which_q <= 2'd0;
			is_float_q  <= 1'b0;
			hex_acc_q   <= 8'h00;
			hex_cnt_q   <= 2'd0;
			line_q      <= POS_BITS'(1);
			col_q       <= '0;
		end else if (take) begin
			mode_q      <= mode_d;
			lit_idx_q   <= lit_idx_d;
			lit_which_q <= lit_which_d;
			is_float_q  <= is_float_d;
			hex_acc_q   <= hex_acc_d;
			hex_cnt_q   <= hex_cnt_d;
			if (is_end) begin
				line_q <= POS_BITS'(1);
				col_q  <= '0;
			end else if (b == CH_LF) begin
				if (line_q != '1) line_q <= line_q + POS_BITS'(1);
				col_q <= '0;
			end else if (col_q != '1) begin
				col_q <= col_q + POS_BITS'(1);
			end
		end
	end
endmodule

>>> rtl/jtl_queue.sv
module jtl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  jtl_pkg::rec_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          empty,
	output jtl_pkg::rec_t rdata
);
	import jtl_pkg::*;
	`include "json_token_lexer_assert.svh"

	rec_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];

	// hold requests between lexer and serializer
	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	`JTL_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "queue count out of range")
	`JTL_ASSERT(a_cnt_up, clk, arst_n, (wr && !rd) |=> (cnt_q == $past(cnt_q) + 2'd1), "queue count did not rise")
	`JTL_ASSERT(a_cnt_dn, clk, arst_n, (rd && !wr) |=> (cnt_q == $past(cnt_q) - 2'd1), "queue count did not fall")
endmodule

>>> rtl/jtl_back.sv
module jtl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  jtl_pkg::rec_t     q_data,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output jtl_pkg::out_item_t result
);
	import jtl_pkg::*;

	logic sub_q;
	ev_t  ev;
	logic last;

	// pick the event of the current request
	assign ev    = sub_q ? q_data.ev1 : q_data.ev0;
	assign last  = q_data.two ? sub_q : 1'b1;
	assign empty = q_empty;
	assign q_rd  = pop & ~q_empty & last;

	assign result.token_kind    = ev.kind;
	assign result.char_value    = ev.ch;
	assign result.error_code    = ev.err;
	assign result.line_number   = q_data.line;
	assign result.column_number = q_data.col;
	assign result.last_of_run   = last;

	// advance through the events of one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (pop && !q_empty) begin
			sub_q <= ~last;
		end
	end
endmodule

>>> rtl/json_token_lexer.sv
// Channel   Handshake           Payload
// item      push / full         in_item_t  (text_byte, end_of_text)
// result    pop / empty         out_item_t (token, char, error, line, column, last)
//
// One byte is accepted per cycle while full is low; a byte that yields two tokens holds the
// result side for two pops. A two-entry queue sits between the lexer and
// the serializer, so full rises only when two lexed bytes wait unread.
// The lexer front end is combinational; each result is registered in the queue.
// Reset clears the lexer state, the positions (line 1, column 0) and the queue.
module json_token_lexer #(
	parameter int POS_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  jtl_pkg::in_item_t  item,
	input  logic               pop,
	output logic               empty,
	output jtl_pkg::out_item_t result
);
	import jtl_pkg::*;

	logic take, wr, q_rd, q_empty;
	rec_t wrec, qrec;

	assign take = push & ~full;

	jtl_front #(.POS_BITS(POS_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item(item), .wr(wr), .rec(wrec)
	);

	jtl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wdata(wrec), .full(full),
		.rd(q_rd), .empty(q_empty), .rdata(qrec)
	);

	jtl_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(qrec), .q_rd(q_rd),
		.pop(pop), .empty(empty), .result(result)
	);
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import jtl_pkg::*;

	localparam int LINE_MAX = 65535;

	// lexer modes
	typedef enum logic [3:0] {
		LM_IDLE, LM_LIT, LM_NSIGN, LM_NINT, LM_NDOT, LM_NFRAC, LM_NEXP, LM_NEXPS,
		LM_NEXPD, LM_STR, LM_ESC, LM_HEX, LM_ERR
	} lex_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_item_t item = '0;
	out_item_t result;

	json_token_lexer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result)
	);

	always #5 clk = ~clk;

	// predictor state
	lex_mode_t  lx_mode;
	logic [2:0] lx_idx;
	logic [1:0] lx_which;
	logic       lx_float;
	logic [7:0] lx_hex;
	logic [1:0] lx_hcnt;
	logic [15:0] lx_line;
	logic [15:0] lx_col;

	out_item_t token_q[$];
	int unsigned run_n;
	int errors = 0;
	int send_idle = 27;
	int recv_idle = 65;

	task automatic lexer_clear();
		lx_mode = LM_IDLE; lx_idx = '0; lx_which = '0; lx_float = 1'b0;
		lx_hex = '0; lx_hcnt = '0; lx_line = 16'd1; lx_col = '0;
	endtask

	task automatic add_token(input logic [4:0] k, input logic [7:0] c,
			input logic [2:0] e);
		out_item_t r;
		r.token_kind = k; r.char_value = c; r.error_code = e;
		r.line_number = lx_line; r.column_number = lx_col; r.last_of_run = 1'b0;
		token_q.push_back(r);
		run_n++;
	endtask

	task automatic lex_fail(input logic [2:0] e);
		add_token(TK_ERROR, 8'h00, e);
		lx_mode = LM_ERR;
	endtask

	function automatic bit is_dig(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	task automatic lex_idle(input logic [7:0] b);
		lx_mode = LM_IDLE;
		lx_float = 1'b0;
		case (b)
			" ", 8'h09, 8'h0D, CH_LF: ;
			":": add_token(TK_COLON, 8'h00, ERR_NONE);
			",": add_token(TK_COMMA, 8'h00, ERR_NONE);
			"[": add_token(TK_LBRACKET, 8'h00, ERR_NONE);
			"]": add_token(TK_RBRACKET, 8'h00, ERR_NONE);
			"{": add_token(TK_LBRACE, 8'h00, ERR_NONE);
			"}": add_token(TK_RBRACE, 8'h00, ERR_NONE);
			"\"": begin add_token(TK_STR_OPEN, 8'h00, ERR_NONE); lx_mode = LM_STR; end
			"-": begin add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NSIGN; end
			"t": begin lx_which = 2'd0; lx_idx = 3'd1; lx_mode = LM_LIT; end
			"f": begin lx_which = 2'd1; lx_idx = 3'd1; lx_mode = LM_LIT; end
			"n": begin lx_which = 2'd2; lx_idx = 3'd1; lx_mode = LM_LIT; end
			default: begin
				if (is_dig(b)) begin
					add_token(TK_NUM_CHAR, b, ERR_NONE);
					lx_mode = LM_NINT;
				end else lex_fail(ERR_INVALID_CHAR);
			end
		endcase
	endtask

	task automatic close_num(input logic [7:0] b);
		add_token(lx_float ? TK_FLOAT_END : TK_INT_END, 8'h00, ERR_NONE);
		lex_idle(b);
	endtask

	function automatic int hex_of(input logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	// work out the tokens of one request
	task automatic lex_request(input in_item_t it);
		logic [7:0] b;
		string w;
		int h;
		logic [7:0] c;
		bit ok;
		b = it.text_byte;
		run_n = 0;
		if (it.end_of_text) begin
			case (lx_mode)
				LM_NINT, LM_NFRAC, LM_NEXP, LM_NEXPD:
					add_token(lx_float ? TK_FLOAT_END : TK_INT_END, 8'h00, ERR_NONE);
				LM_NSIGN, LM_NDOT, LM_NEXPS: add_token(TK_ERROR, 8'h00, ERR_EXP_DIGIT);
				LM_LIT, LM_STR, LM_ESC, LM_HEX: add_token(TK_ERROR, 8'h00, ERR_UNTERM);
				default: ;
			endcase
			add_token(TK_END, 8'h00, ERR_NONE);
			lexer_clear();
		end else begin
			case (lx_mode)
				LM_LIT: begin
					w = (lx_which == 2'd1) ? "false" : (lx_which == 2'd2) ? "null" : "true";
					if (lx_idx < w.len() && b == w[lx_idx]) begin
						lx_idx = lx_idx + 3'd1;
						if (lx_idx == w.len()) begin
							add_token(5'(TK_TRUE + ((lx_which == 2'd3) ? 2'd0 : lx_which)),
								8'h00, ERR_NONE);
							lx_mode = LM_IDLE;
						end
					end else lex_fail(ERR_INVALID_CHAR);
				end
				LM_NSIGN: begin
					if (is_dig(b)) begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NINT;
					end else lex_fail(ERR_EXP_DIGIT);
				end
				LM_NINT, LM_NFRAC: begin
					if (is_dig(b)) add_token(TK_NUM_CHAR, b, ERR_NONE);
					else if (b == "." && lx_mode == LM_NINT) begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NDOT;
					end else if (b == "e" || b == "E") begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_float = 1'b1;
						lx_mode = LM_NEXP;
					end else close_num(b);
				end
				LM_NDOT: begin
					if (is_dig(b)) begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_float = 1'b1;
						lx_mode = LM_NFRAC;
					end else lex_fail(ERR_EXP_DIGIT);
				end
				LM_NEXP: begin
					if (is_dig(b)) begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NEXPD;
					end else if (b == "+" || b == "-") begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NEXPS;
					end else close_num(b);
				end
				LM_NEXPS: begin
					if (is_dig(b)) begin
						add_token(TK_NUM_CHAR, b, ERR_NONE); lx_mode = LM_NEXPD;
					end else lex_fail(ERR_EXP_DIGIT);
				end
				LM_NEXPD: begin
					if (is_dig(b)) add_token(TK_NUM_CHAR, b, ERR_NONE);
					else close_num(b);
				end
				LM_STR: begin
					if (b == "\"") begin
						add_token(TK_STR_CLOSE, 8'h00, ERR_NONE); lx_mode = LM_IDLE;
					end else if (b == "\\") lx_mode = LM_ESC;
					else add_token(TK_STR_CHAR, b, ERR_NONE);
				end
				LM_ESC: begin
					ok = 1'b1;
					c = 8'h00;
					case (b)
						"\"", "\\", "/": c = b;
						"b": c = 8'h08;
						"f": c = 8'h0C;
						"n": c = CH_LF;
						"r": c = 8'h0D;
						"t": c = 8'h09;
						default: ok = 1'b0;
					endcase
					if (b == "u") begin
						lx_hex = '0; lx_hcnt = '0; lx_mode = LM_HEX;
					end else if (ok) begin
						add_token(TK_STR_CHAR, c, ERR_NONE); lx_mode = LM_STR;
					end else lex_fail(ERR_BAD_ESCAPE);
				end
				LM_HEX: begin
					h = hex_of(b);
					if (h < 0) lex_fail(ERR_BAD_HEX);
					else begin
						lx_hex = {lx_hex[3:0], 4'(h)};
						if (lx_hcnt == 2'd3) begin
							add_token(TK_STR_CHAR, lx_hex, ERR_NONE); lx_hcnt = 2'd0;
							lx_mode = LM_STR;
						end else lx_hcnt = lx_hcnt + 2'd1;
					end
				end
				LM_ERR: ;
				default: lex_idle(b);
			endcase
			if (b == CH_LF) begin
				if (lx_line < LINE_MAX) lx_line++;
				lx_col = '0;
			end else if (lx_col < LINE_MAX) lx_col++;
		end
		if (run_n > 0) token_q[$].last_of_run = 1'b1;
	endtask

	// accept a request at the rising edge, hold it until then
	task automatic send_item(input in_item_t it);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		lex_request(it);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		in_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.text_byte = s[i]; it.end_of_text = 1'b0;
			send_item(it);
		end
	endtask

	task automatic send_end();
		in_item_t it;
		it.text_byte = 8'($urandom); it.end_of_text = 1'b1;
		send_item(it);
	endtask

	// check results at the rising edge
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && pop && !empty) begin
			if (token_q.size() == 0) begin
				$error("unexpected result kind=%0d", result.token_kind);
				errors++;
			end else begin
				e = token_q.pop_front();
				if (result.token_kind !== e.token_kind) begin
					$error("token_kind exp %0d got %0d", e.token_kind, result.token_kind);
					errors++;
				end
				if (result.char_value !== e.char_value) begin
					$error("char_value exp %0h got %0h", e.char_value, result.char_value);
					errors++;
				end
				if (result.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, result.error_code);
					errors++;
				end
				if (result.line_number !== e.line_number) begin
					$error("line_number exp %0d got %0d", e.line_number, result.line_number);
					errors++;
				end
				if (result.column_number !== e.column_number) begin
					$error("column_number exp %0d got %0d", e.column_number,
						result.column_number);
					errors++;
				end
				if (result.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0d got %0d", e.last_of_run, result.last_of_run);
					errors++;
				end
			end
		end
	end

	// random stall on the result side
	always @(negedge clk) begin
		pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
	end

	// directed rows: a byte, an end flag and, where obvious, the kind and error
	typedef struct {
		logic [7:0] b;
		logic       eot;
		logic [4:0] kind;
		logic [2:0] err;
		bit         known;
	} row_t;

	row_t rows[$];

	task automatic add_row(input logic [7:0] b, input logic eot, input logic [4:0] k,
			input logic [2:0] e, input bit known);
		row_t r;
		r.b = b; r.eot = eot; r.kind = k; r.err = e; r.known = known;
		rows.push_back(r);
	endtask

	// random fragments of mostly well formed text
	function automatic string rand_fragment();
		string s;
		int n;
		string hx;
		string esc;
		hx = "0123456789abcdefABCDEF";
		esc = "\"\\/bfnrt";
		case ($urandom_range(11))
			0: s = "true";
			1: s = "false";
			2: s = "null";
			3: begin
				s = ($urandom_range(1)) ? "-" : "";
				n = $urandom_range(1, 3);
				repeat (n) s = {s, string'(8'("0" + $urandom_range(9)))};
				if ($urandom_range(1)) s = {s, ".", string'(8'("0" + $urandom_range(9)))};
				if ($urandom_range(1)) begin
					s = {s, ($urandom_range(1)) ? "e" : "E"};
					case ($urandom_range(2))
						0: s = {s, "+7"};
						1: s = {s, "-12"};
						default: if ($urandom_range(1)) s = {s, "3"};
					endcase
				end
			end
			4, 5: begin
				s = "\"";
				n = $urandom_range(0, 5);
				repeat (n) begin
					case ($urandom_range(5))
						0: s = {s, "\\", string'(8'(esc[$urandom_range(7)]))};
						1: begin
							s = {s, "\\u"};
							repeat (4) s = {s, string'(8'(hx[$urandom_range(21)]))};
						end
						2: s = {s, string'(8'($urandom_range(1, 255)))};
						default: s = {s, string'(8'($urandom_range(32, 126)))};
					endcase
				end
				s = {s, "\""};
			end
			6: s = ($urandom_range(1)) ? "[" : "]";
			7: s = ($urandom_range(1)) ? "{" : "}";
			8: s = ($urandom_range(1)) ? ":" : ",";
			9: s = ($urandom_range(1)) ? " " : "\n";
			default: s = {" ", "\t", "\r"};
		endcase
		return s;
	endfunction

	initial begin
		in_item_t it;
		int sent;
		string s;
		lexer_clear();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: punctuation, literals, errors, extremes, saturation-free edges
		add_row(8'h00, 1'b1, TK_END, ERR_NONE, 1'b1);
		add_row(":", 1'b0, TK_COLON, ERR_NONE, 1'b1);
		add_row(",", 1'b0, TK_COMMA, ERR_NONE, 1'b1);
		add_row("[", 1'b0, TK_LBRACKET, ERR_NONE, 1'b1);
		add_row("]", 1'b0, TK_RBRACKET, ERR_NONE, 1'b1);
		add_row("{", 1'b0, TK_LBRACE, ERR_NONE, 1'b1);
		add_row("}", 1'b0, TK_RBRACE, ERR_NONE, 1'b1);
		add_row("-", 1'b0, TK_NUM_CHAR, ERR_NONE, 1'b1);
		add_row(8'hFF, 1'b1, TK_END, ERR_NONE, 1'b0);
		add_row("1", 1'b0, TK_NUM_CHAR, ERR_NONE, 1'b1);
		add_row(".", 1'b0, TK_NUM_CHAR, ERR_NONE, 1'b1);
		add_row("x", 1'b0, TK_ERROR, ERR_EXP_DIGIT, 1'b1);
		add_row(8'h00, 1'b1, TK_END, ERR_NONE, 1'b1);
		add_row(8'hFF, 1'b0, TK_ERROR, ERR_INVALID_CHAR, 1'b1);
		add_row(8'h00, 1'b1, TK_END, ERR_NONE, 1'b1);
		add_row("\"", 1'b0, TK_STR_OPEN, ERR_NONE, 1'b1);
		add_row("\\", 1'b0, TK_END, ERR_NONE, 1'b0);
		add_row("q", 1'b0, TK_ERROR, ERR_BAD_ESCAPE, 1'b1);
		add_row(8'h00, 1'b1, TK_END, ERR_NONE, 1'b1);
		add_row("t", 1'b0, TK_END, ERR_NONE, 1'b0);
		add_row("x", 1'b0, TK_ERROR, ERR_INVALID_CHAR, 1'b1);
		add_row(8'h00, 1'b1, TK_END, ERR_NONE, 1'b1);
		foreach (rows[i]) begin
			it.text_byte = rows[i].b; it.end_of_text = rows[i].eot;
			send_item(it);
			if (rows[i].known && token_q.size() > 0) begin
				if (token_q[$].token_kind !== rows[i].kind) begin
					$error("token_kind exp %0d got %0d", rows[i].kind,
						token_q[$].token_kind);
					errors++;
				end
				if (token_q[$].error_code !== rows[i].err) begin
					$error("error_code exp %0d got %0d", rows[i].err,
						token_q[$].error_code);
					errors++;
				end
			end
		end
		// literals, exponents, hex escapes, zero byte, bad hex, unterminated
		send_text("true false null 1e 2E+5 0.5e-3 007,\"\\u00410\\u1200\\n\\/\"");
		send_end();
		send_text("\"\\u12g"); send_end();
		send_text("\"ab"); send_end();
		send_text("3e-"); send_end();
		send_text("fal"); send_end();

		// random: mostly well formed, some noise
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 27 : (ph == 1) ? 65 : 0;
			recv_idle = (ph == 0) ? 65 : (ph == 1) ? 27 : 0;
			while (sent < 450 * (ph + 1)) begin
				if ($urandom_range(19) == 0) begin
					it.text_byte = 8'($urandom); it.end_of_text = 1'b0;
					send_item(it);
					sent++;
				end else if ($urandom_range(29) == 0) begin
					send_end();
					sent++;
				end else begin
					s = rand_fragment();
					send_text(s);
					sent += s.len();
				end
			end
		end
		send_end();
		push <= 1'b0;

		while (token_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
